// ===== hw/rtl/sgrg_pkg.sv =====
// ----------------------------------------------------------------------------
// sgrg_pkg
// Shared types, constants and helpers for the seeded grid region grower.
// ----------------------------------------------------------------------------
package sgrg_pkg;

  localparam int GRID_X     = 64;
  localparam int GRID_Y     = 64;
  localparam int GRID_Z     = 32;
  localparam int LABEL_BITS = 16;

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int IDX_W = $clog2(CELLS);
  // working width for bound arithmetic on coordinates
  localparam int CW    = 11;
  // squared distances: two 12-bit squares summed, shifted by 8, plus dz term
  localparam int DW    = 23;
  localparam int LIM_W = 22;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_UP   = 2'd1,
    REQ_DOWN = 2'd2,
    REQ_READ = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_REACH_XY = 2'd0,
    CFG_REACH_Z  = 2'd1,
    CFG_XY_LIM   = 2'd2,
    CFG_BEST_LIM = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOOK,
    ST_EVAL,
    ST_CHECK,
    ST_WB,
    ST_FIN
  } state_e;

  typedef logic signed [LABEL_BITS-1:0] label_t;

  typedef struct packed {
    req_e               req_type;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic [4:0]         cell_z;
    logic signed [15:0] seed_label;
  } in_beat_t;

  typedef struct packed {
    logic               status;
    logic signed [15:0] cell_label;
    logic               parent_found;
    logic [5:0]         parent_x;
    logic [5:0]         parent_y;
    logic [4:0]         parent_z;
  } out_beat_t;

  typedef struct packed {
    logic [4:0] z;
    logic [5:0] y;
    logic [5:0] x;
  } coord_t;

  typedef struct packed {
    logic [5:0]       reach_xy;
    logic [4:0]       reach_z;
    logic [LIM_W-1:0] xy_limit_sq;
    logic [LIM_W-1:0] best_limit_sq;
  } cfg_t;

  typedef struct packed {
    logic             lab_we;
    logic [IDX_W-1:0] lab_addr;
    label_t           lab_wd;
    logic             cell_we;
    logic [IDX_W-1:0] cell_addr;
    logic             lnk_wd;
    coord_t           par_wd;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] voxel_idx(logic [5:0] x, logic [5:0] y,
                                                 logic [4:0] z);
    logic [31:0] v;
    v = (32'(z) * 32'(GRID_Y) + 32'(y)) * 32'(GRID_X) + 32'(x);
    return v[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/sgrg_ram.sv =====
// ----------------------------------------------------------------------------
// sgrg_ram
// Single-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module sgrg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hw/rtl/sgrg_core.sv =====
// ----------------------------------------------------------------------------
// sgrg_core
// Sequencer and shared distance/compare unit for the region grower.
// ----------------------------------------------------------------------------
module sgrg_core import sgrg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o,
  output mem_req_t  mem_o,
  input  label_t    lab_rd_i,
  input  logic      lnk_rd_i,
  input  coord_t    par_rd_i
);

  state_e st_q, st_d;

  in_beat_t         in_q;
  logic             ok_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] clr_q, clr_d;
  label_t           lab_q, lab_d;
  label_t           base_q, base_d;
  logic             lnk_q, lnk_d;
  coord_t           par_q, par_d;
  logic             status_q, status_d;
  logic [5:0]       x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic [4:0]       z1_q, z1_d;
  coord_t           pos_q, pos_d;
  logic [DW-1:0]    best_q, best_d, d_q, d_d;
  out_beat_t        out_q;
  logic             out_vld_q;

  logic accept, out_take, clr_last;

  // bound arithmetic
  logic [CW-1:0] xe, ye, ze, rxy, rz;
  logic [CW-1:0] bx0, bx1, by0, by1, bz0, bz1;
  logic          z_empty;

  // distance unit
  logic [5:0]    dx, dy;
  logic [4:0]    dz;
  logic [DW-1:0] dxy, dsq;
  logic          in_reach;

  // scan advance
  coord_t nxt;
  logic   scan_last;

  logic seed_ok;
  label_t seed_lab;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = out_vld_q && !out_stall_i;
  assign clr_last = (clr_q == IDX_W'(CELLS - 1));
  assign in_stall_o = (st_q != ST_IDLE);

  always_comb begin
    logic signed [31:0] s32;
    s32      = 32'(in_q.seed_label);
    seed_lab = LABEL_BITS'(s32);
    seed_ok  = 1'b1;
  end

  always_comb begin
    xe  = CW'(in_q.cell_x);
    ye  = CW'(in_q.cell_y);
    ze  = CW'(in_q.cell_z);
    rxy = CW'(cfg_i.reach_xy);
    rz  = CW'(cfg_i.reach_z);
    bx0 = (xe >= rxy) ? xe - rxy : '0;
    bx1 = (xe + rxy < CW'(GRID_X)) ? xe + rxy : CW'(GRID_X - 1);
    by0 = (ye >= rxy) ? ye - rxy : '0;
    by1 = (ye + rxy < CW'(GRID_Y)) ? ye + rxy : CW'(GRID_Y - 1);
    if (in_q.req_type == REQ_UP) begin
      z_empty = (rz == '0) || (ze == '0);
      bz0     = (ze >= rz) ? ze - rz : '0;
      bz1     = ze - CW'(1);
    end else begin
      z_empty = (rz == '0) || (ze + CW'(1) >= CW'(GRID_Z));
      bz0     = ze + CW'(1);
      bz1     = (ze + rz < CW'(GRID_Z)) ? ze + rz : CW'(GRID_Z - 1);
    end
  end

  always_comb begin
    logic [11:0] sx, sy;
    logic [9:0]  sz;
    dx   = (pos_q.x > in_q.cell_x) ? pos_q.x - in_q.cell_x : in_q.cell_x - pos_q.x;
    dy   = (pos_q.y > in_q.cell_y) ? pos_q.y - in_q.cell_y : in_q.cell_y - pos_q.y;
    dz   = (pos_q.z > in_q.cell_z) ? pos_q.z - in_q.cell_z : in_q.cell_z - pos_q.z;
    sx   = 12'(dx) * 12'(dx);
    sy   = 12'(dy) * 12'(dy);
    sz   = 10'(dz) * 10'(dz);
    dxy  = (DW'(sx) + DW'(sy)) << 8;
    dsq  = dxy + (DW'(sz) << 8);
    in_reach = (dxy < DW'(cfg_i.xy_limit_sq)) && (dsq < best_q);
  end

  // order of the box walk: Y fastest, then X, then Z
  always_comb begin
    nxt       = pos_q;
    scan_last = 1'b0;
    if (pos_q.y < y1_q) begin
      nxt.y = pos_q.y + 6'd1;
    end else begin
      nxt.y = y0_q;
      if (pos_q.x < x1_q) begin
        nxt.x = pos_q.x + 6'd1;
      end else begin
        nxt.x = x0_q;
        if (pos_q.z < z1_q) begin
          nxt.z = pos_q.z + 5'd1;
        end else begin
          scan_last = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLEAR: if (clr_last) st_d = ST_IDLE;
      ST_IDLE:  if (accept) st_d = ST_READ;
      ST_READ:  st_d = ST_LOOK;
      ST_LOOK: begin
        if (!ok_q || in_q.req_type == REQ_LOAD || in_q.req_type == REQ_READ
            || lnk_rd_i || z_empty) begin
          st_d = ST_FIN;
        end else begin
          st_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (in_reach) st_d = ST_CHECK;
        else if (scan_last) st_d = ST_WB;
      end
      ST_CHECK: st_d = scan_last ? ST_WB : ST_EVAL;
      ST_WB:    st_d = ST_FIN;
      ST_FIN:   if (!out_vld_q || out_take) st_d = ST_IDLE;
      default:  st_d = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d    = clr_q;
    lab_d    = lab_q;
    base_d   = base_q;
    lnk_d    = lnk_q;
    par_d    = par_q;
    status_d = status_q;
    x0_d = x0_q; x1_d = x1_q; y0_d = y0_q; y1_d = y1_q; z1_d = z1_q;
    pos_d  = pos_q;
    best_d = best_q;
    d_d    = d_q;

    mem_o.lab_we    = 1'b0;
    mem_o.lab_addr  = idx_q;
    mem_o.lab_wd    = lab_q;
    mem_o.cell_we   = 1'b0;
    mem_o.cell_addr = idx_q;
    mem_o.lnk_wd    = lnk_q;
    mem_o.par_wd    = par_q;

    case (st_q)
      ST_CLEAR: begin
        mem_o.lab_we    = 1'b1;
        mem_o.lab_addr  = clr_q;
        mem_o.lab_wd    = '1;
        mem_o.cell_we   = 1'b1;
        mem_o.cell_addr = clr_q;
        mem_o.lnk_wd    = 1'b0;
        clr_d           = clr_q + IDX_W'(1);
      end
      ST_LOOK: begin
        lab_d    = lab_rd_i;
        base_d   = lab_rd_i;
        lnk_d    = lnk_rd_i;
        par_d    = par_rd_i;
        status_d = 1'b0;
        x0_d = bx0[5:0]; x1_d = bx1[5:0];
        y0_d = by0[5:0]; y1_d = by1[5:0];
        z1_d = bz1[4:0];
        pos_d  = '{z: bz0[4:0], y: by0[5:0], x: bx0[5:0]};
        best_d = DW'(cfg_i.best_limit_sq);
        if (ok_q) begin
          if (in_q.req_type == REQ_LOAD) begin
            lab_d        = seed_ok ? seed_lab : lab_rd_i;
            mem_o.lab_we = 1'b1;
            mem_o.lab_wd = seed_lab;
          end else if ((in_q.req_type == REQ_UP || in_q.req_type == REQ_DOWN)
                       && lnk_rd_i) begin
            status_d = 1'b1;
          end
        end
      end
      ST_EVAL: begin
        mem_o.lab_addr = voxel_idx(pos_q.x, pos_q.y, pos_q.z);
        d_d            = dsq;
        if (!in_reach) pos_d = nxt;
      end
      ST_CHECK: begin
        pos_d = nxt;
        if (!lab_rd_i[LABEL_BITS-1]) begin
          if (!base_q[LABEL_BITS-1]) begin
            if (base_q == lab_rd_i && in_q.req_type == REQ_UP) begin
              best_d = d_q;
              par_d  = pos_q;
              lnk_d  = 1'b1;
            end
          end else begin
            best_d = d_q;
            par_d  = pos_q;
            lnk_d  = 1'b1;
            lab_d  = lab_rd_i;
          end
        end
      end
      ST_WB: begin
        mem_o.lab_we  = 1'b1;
        mem_o.cell_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      if (st_q == ST_FIN && (!out_vld_q || out_take)) begin
        out_vld_q <= 1'b1;
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [31:0] l32;
    l32 = 32'(lab_q);
    if (accept) begin
      in_q  <= in_beat_i;
      idx_q <= voxel_idx(in_beat_i.cell_x, in_beat_i.cell_y, in_beat_i.cell_z);
      ok_q  <= (CW'(in_beat_i.cell_x) < CW'(GRID_X)) &&
               (CW'(in_beat_i.cell_y) < CW'(GRID_Y)) &&
               (CW'(in_beat_i.cell_z) < CW'(GRID_Z));
    end
    lab_q    <= lab_d;
    base_q   <= base_d;
    lnk_q    <= lnk_d;
    par_q    <= par_d;
    status_q <= status_d;
    x0_q <= x0_d; x1_q <= x1_d; y0_q <= y0_d; y1_q <= y1_d; z1_q <= z1_d;
    pos_q  <= pos_d;
    best_q <= best_d;
    d_q    <= d_d;
    if (st_q == ST_FIN && (!out_vld_q || out_take)) begin
      out_q.status       <= ok_q && status_q;
      out_q.cell_label   <= ok_q ? l32[15:0] : 16'hFFFF;
      out_q.parent_found <= ok_q && lnk_q;
      out_q.parent_x     <= (ok_q && lnk_q) ? par_q.x : '0;
      out_q.parent_y     <= (ok_q && lnk_q) ? par_q.y : '0;
      out_q.parent_z     <= (ok_q && lnk_q) ? par_q.z : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  // no beat taken while the stores are being cleared
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLEAR) |-> in_stall_o)
    else $error("input accepted during clearing pass");

  // a result is only loaded from the finish step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(st_q == ST_FIN))
    else $error("result appeared outside finish step");

  // label store written only by clear, load or write-back
  a_lab_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.lab_we |-> (st_q == ST_CLEAR || st_q == ST_LOOK || st_q == ST_WB))
    else $error("stray label store write");

  // a probe always follows a passing distance check
  a_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CHECK) |-> $past(st_q == ST_EVAL && in_reach))
    else $error("label probe without distance pass");

endmodule

// ===== hw/rtl/seeded_grid_region_growing.sv =====
// ----------------------------------------------------------------------------
// seeded_grid_region_growing
// Voxel-grid seeded region grower: label, link and parent stores and sequencer.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 131072 voxels
// with stall held high; configuration writes are taken throughout. A grow
// request walks the clipped search box voxel by voxel: a voxel that fails
// the distance limits is skipped, and one that passes has its label probed
// through the single label-store port, which sets the rate; an already
// linked cell returns without a scan. A finished result waits in an
// output register, so the next beat can be taken meanwhile.
module seeded_grid_region_growing import sgrg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [LIM_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_beat_t         in_beat_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_beat_t        out_beat_o
);

  cfg_t     cfg_q;
  mem_req_t mem;
  label_t   lab_rd;
  logic     lnk_rd;
  coord_t   par_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reach_xy      <= 6'd1;
      cfg_q.reach_z       <= 5'd3;
      cfg_q.xy_limit_sq   <= LIM_W'(256);
      cfg_q.best_limit_sq <= LIM_W'(2560);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REACH_XY: cfg_q.reach_xy      <= cfg_data_i[5:0];
        CFG_REACH_Z:  cfg_q.reach_z       <= cfg_data_i[4:0];
        CFG_XY_LIM:   cfg_q.xy_limit_sq   <= cfg_data_i;
        CFG_BEST_LIM: cfg_q.best_limit_sq <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sgrg_ram #(.WIDTH(LABEL_BITS), .DEPTH(CELLS)) u_lab_ram (
    .clk_i   (clk_i),
    .we_i    (mem.lab_we),
    .addr_i  (mem.lab_addr),
    .wdata_i (mem.lab_wd),
    .rdata_o (lab_rd)
  );

  sgrg_ram #(.WIDTH(1), .DEPTH(CELLS)) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (mem.cell_we),
    .addr_i  (mem.cell_addr),
    .wdata_i (mem.lnk_wd),
    .rdata_o (lnk_rd)
  );

  // parent store has no reset; its data is only used where the link flag is set
  sgrg_ram #(.WIDTH($bits(coord_t)), .DEPTH(CELLS)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (mem.cell_we && mem.lnk_wd),
    .addr_i  (mem.cell_addr),
    .wdata_i (mem.par_wd),
    .rdata_o (par_rd)
  );

  sgrg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .mem_o       (mem),
    .lab_rd_i    (lab_rd),
    .lnk_rd_i    (lnk_rd),
    .par_rd_i    (par_rd)
  );

endmodule

// ===== dv/tb_seeded_grid_region_growing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seeded_grid_region_growing
// Self-checking bench for the voxel region grower. A behavioural grid model
// predicts every result beat. A directed pass covers grid edges, ties,
// repeated label adoption and linked cells. Random phases then load seeds
// into small clusters and grow up and down across them, under several
// register settings and with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_seeded_grid_region_growing;
  import sgrg_pkg::*;

  localparam int CYCLE_LIMIT = 12000000;
  localparam int HOLD_CYCLES = 3000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  cfg_idx_e         cfg_idx = CFG_REACH_XY;
  logic [LIM_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_beat_t         in_beat = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_beat;

  always #4 clk = ~clk;

  seeded_grid_region_growing dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  // grid model
  logic signed [15:0] grid_label [CELLS];
  int unsigned        grid_parent [CELLS];
  bit                 grid_linked [CELLS];
  int unsigned        m_reach_xy, m_reach_z, m_xy_lim, m_best_lim;

  out_beat_t pending_beats [$];
  int        mismatches = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;
  longint    cycles = 0;

  function automatic int unsigned cell_index(int x, int y, int z);
    return (z * GRID_Y + y) * GRID_X + x;
  endfunction

  function automatic void scan_box(int x, int y, int z, bit up);
    int unsigned idx, best, dxy, d, c;
    int x0, x1, y0, y1, z0, z1, dx, dy, dz;
    logic signed [15:0] base, lab;
    idx  = cell_index(x, y, z);
    base = grid_label[idx];
    best = m_best_lim;
    x0 = (x >= m_reach_xy) ? x - m_reach_xy : 0;
    x1 = (x + m_reach_xy < GRID_X) ? x + m_reach_xy : GRID_X - 1;
    y0 = (y >= m_reach_xy) ? y - m_reach_xy : 0;
    y1 = (y + m_reach_xy < GRID_Y) ? y + m_reach_xy : GRID_Y - 1;
    if (m_reach_z == 0) return;
    if (up) begin
      if (z == 0) return;
      z1 = z - 1;
      z0 = (z >= m_reach_z) ? z - m_reach_z : 0;
    end else begin
      if (z + 1 >= GRID_Z) return;
      z0 = z + 1;
      z1 = (z + m_reach_z < GRID_Z) ? z + m_reach_z : GRID_Z - 1;
    end
    for (int zz = z0; zz <= z1; zz++)
      for (int xx = x0; xx <= x1; xx++)
        for (int yy = y0; yy <= y1; yy++) begin
          dx  = xx - x;
          dy  = yy - y;
          dz  = zz - z;
          dxy = (dx * dx + dy * dy) * 256;
          if (dxy >= m_xy_lim) continue;
          d = dxy + dz * dz * 256;
          if (d >= best) continue;
          c   = cell_index(xx, yy, zz);
          lab = grid_label[c];
          if (lab < 0) continue;
          if (base >= 0) begin
            if (base == lab && up) begin
              best = d;
              grid_parent[idx] = c;
              grid_linked[idx] = 1'b1;
            end
          end else begin
            best = d;
            grid_parent[idx] = c;
            grid_linked[idx] = 1'b1;
            grid_label[idx]  = lab;
          end
        end
  endfunction

  function automatic out_beat_t predict_result(in_beat_t b);
    out_beat_t   r;
    int unsigned idx, p;
    r   = '0;
    idx = cell_index(b.cell_x, b.cell_y, b.cell_z);
    case (b.req_type)
      REQ_LOAD: grid_label[idx] = b.seed_label;
      REQ_UP, REQ_DOWN: begin
        if (grid_linked[idx]) r.status = 1'b1;
        else scan_box(b.cell_x, b.cell_y, b.cell_z, b.req_type == REQ_UP);
      end
      default: ;
    endcase
    r.cell_label = grid_label[idx];
    if (grid_linked[idx]) begin
      p = grid_parent[idx];
      r.parent_found = 1'b1;
      r.parent_x = 6'(p % GRID_X);
      r.parent_y = 6'((p / GRID_X) % GRID_Y);
      r.parent_z = 5'(p / (GRID_X * GRID_Y));
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_beat);
      end else begin
        if (out_beat !== pending_beats[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", pending_beats[0], out_beat);
        end
        void'(pending_beats.pop_front());
      end
    end
  end

  initial begin
    @(posedge clk);
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // receiver stalls
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(req_e req, int x, int y, int z, logic signed [15:0] lab);
    in_beat_t b;
    int       gap;
    b = '{req_type: req, cell_x: 6'(x), cell_y: 6'(y), cell_z: 5'(z), seed_label: lab};
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    pending_beats.push_back(predict_result(b));
    gap = $urandom_range(0, 9);
    if (quiet || gap < 6) gap = 0;
    else if (gap < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(int rxy, int rz, int xyl, int bl);
    int v [4];
    v = '{rxy, rz, xyl, bl};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_idx_e'(i);
      cfg_data <= LIM_W'(v[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_reach_xy = rxy;
    m_reach_z  = rz;
    m_xy_lim   = xyl;
    m_best_lim = bl;
  endtask

  task automatic test_directed();
    write_regs(2, 3, 2600, 4194303);
    // nearer seeds found later in the scan replace the adopted label
    send_beat(REQ_LOAD, 10, 10, 2, 5);
    send_beat(REQ_LOAD, 9, 10, 2, 7);
    send_beat(REQ_LOAD, 11, 11, 3, 3);
    send_beat(REQ_UP, 10, 10, 4, 0);
    send_beat(REQ_UP, 10, 10, 4, 0);      // already linked
    send_beat(REQ_LOAD, 10, 10, 5, 3);
    send_beat(REQ_UP, 10, 10, 5, 0);      // labelled cell, same label below
    // tie: lower X is scanned first
    send_beat(REQ_LOAD, 20, 20, 1, 11);
    send_beat(REQ_LOAD, 22, 20, 1, 12);
    send_beat(REQ_UP, 21, 20, 2, 0);
    // labelled cell growing down never links
    send_beat(REQ_LOAD, 30, 30, 5, 4);
    send_beat(REQ_LOAD, 30, 30, 6, 4);
    send_beat(REQ_DOWN, 30, 30, 5, 0);
    // grid corners and label extremes
    send_beat(REQ_LOAD, 63, 63, 31, 16'sh7fff);
    send_beat(REQ_LOAD, 0, 0, 0, 16'sh8000);
    send_beat(REQ_LOAD, 0, 63, 30, -16'sd1);
    send_beat(REQ_UP, 0, 0, 0, 0);
    send_beat(REQ_DOWN, 63, 63, 31, 0);
    send_beat(REQ_DOWN, 63, 63, 30, 0);
    send_beat(REQ_READ, 63, 63, 30, 16'sh5a5a);
    send_beat(REQ_READ, 0, 0, 0, 0);
    send_beat(REQ_LOAD, 10, 10, 4, 9);    // load on a linked cell
    write_regs(2, 0, 2600, 4194303);
    send_beat(REQ_UP, 22, 20, 2, 0);      // no layers scanned
    send_beat(REQ_READ, 63, 0, 0, 0);
  endtask

  task automatic test_random_phase(int rxy, int rz, int xyl, int bl, int grows, bit hold);
    int bx, by, bz, r;
    write_regs(rxy, rz, xyl, bl);
    bx = $urandom_range(0, 58);
    by = $urandom_range(0, 58);
    bz = $urandom_range(0, 26);
    if (hold) hold_req = 1'b1;
    repeat (12)
      send_beat(REQ_LOAD, bx + $urandom_range(0, 5), by + $urandom_range(0, 5),
                bz + $urandom_range(0, 5),
                ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)));
    repeat (grows)
      send_beat(REQ_UP, bx + $urandom_range(0, 5), by + $urandom_range(0, 5),
                bz + $urandom_range(0, 5), 16'($urandom));
    repeat (grows)
      send_beat(REQ_DOWN, bx + $urandom_range(0, 5), by + $urandom_range(0, 5),
                bz + $urandom_range(0, 5), 16'($urandom));
    repeat (10) begin
      r = $urandom_range(0, 3);
      if (r == 0 || r == 3)
        send_beat(req_e'(r), $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 31), 16'($urandom));
      else
        send_beat(REQ_READ, bx + $urandom_range(0, 5), by + $urandom_range(0, 5),
                  bz + $urandom_range(0, 5), 16'($urandom));
    end
  endtask

  task automatic test_random();
    test_random_phase(1, 3, 256, 2560, 30, 1'b1);
    quiet = 1'b1;
    test_random_phase(2, 2, 1300, 3000, 30, 1'b0);
    quiet = 1'b0;
    test_random_phase(3, 1, 2600, 4194303, 30, 1'b0);
    test_random_phase(0, 4, 0, 1000, 25, 1'b0);
    test_random_phase(2, 31, 4194303, 4194303, 30, 1'b0);
    test_random_phase(63, 1, 4194303, 4194303, 12, 1'b0);
    test_random_phase(1, 2, 600, 0, 25, 1'b0);
    test_random_phase(2, 2, 3000, 5000, 30, 1'b0);
    test_random_phase(2, 3, 2600, 2400, 30, 1'b0);
  endtask

  initial begin
    foreach (grid_label[i]) grid_label[i] = -16'sd1;
    m_reach_xy = 1;
    m_reach_z  = 3;
    m_xy_lim   = 256;
    m_best_lim = 2560;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
